FILE: sv/lpch_pkg.sv
// ----------------------------------------------------------------------------
// lpch_pkg
// types, codes and defaults shared by the coordinate hash table modules
// ----------------------------------------------------------------------------
package lpch_pkg;

    localparam int TableDepthDefault = 256;
    localparam int CapW              = 9;
    localparam int KeyW              = 16;
    localparam int CntW              = 32;
    localparam int DivSteps          = 32;
    localparam int EntryMax          = 511;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] key_x;
        logic signed [15:0] key_y;
        logic [7:0]         entry_flags;
        logic [15:0]        entry_id;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [7:0]  out_flags;
        logic [15:0] out_id;
        t_status     status;
        logic [31:0] access_count;
        logic [31:0] miss_count;
        logic [8:0]  entry_count;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  flags;
        logic [15:0] id;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic    clr_wr;
        logic    load;
        logic    div_step;
        logic    rd_at;
        logic    rd_home;
        logic    wr_at;
        logic    wr_home;
        logic    step;
        logic    save;
        logic    set_res;
        t_status res_status;
        logic    res_found;
        logic    res_miss;
        logic    fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic is_lookup;
        logic rd_valid;
        logic rd_match;
        logic at_home;
        logic sweep_last;
    } t_stat;

endpackage

FILE: sv/lpch_ctrl.sv
// ----------------------------------------------------------------------------
// lpch_ctrl
// sequencer: clearing pass, home slot division, probe, move and swap steps
// ----------------------------------------------------------------------------
module lpch_ctrl
    import lpch_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_READ   = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_READH  = 9'b000100000,
        S_WRAT   = 9'b001000000,
        S_WRHOME = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_at = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.set_res = 1'b1;
                if (!i_stat.is_lookup) begin
                    if (!i_stat.rd_valid) begin
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_miss   = !i_stat.at_home;
                        n_state          = i_stat.at_home ? S_WRHOME : S_READH;
                    end else if (i_stat.sweep_last) begin
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_FIN;
                    end else begin
                        o_cmd.set_res = 1'b0;
                        o_cmd.step    = 1'b1;
                        n_state       = S_READ;
                    end
                end else begin
                    if (!i_stat.rd_valid) begin
                        o_cmd.res_status = ST_NOT_FOUND;
                        o_cmd.res_miss   = !i_stat.at_home;
                        n_state          = S_FIN;
                    end else if (i_stat.rd_match) begin
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_found  = 1'b1;
                        o_cmd.res_miss   = !i_stat.at_home;
                        o_cmd.save       = 1'b1;
                        n_state          = i_stat.at_home ? S_FIN : S_READH;
                    end else if (i_stat.sweep_last) begin
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_FIN;
                    end else begin
                        o_cmd.set_res = 1'b0;
                        o_cmd.step    = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_READH: begin
                o_cmd.rd_home = 1'b1;
                n_state       = S_WRAT;
            end
            S_WRAT: begin
                o_cmd.wr_at = 1'b1;
                n_state     = S_WRHOME;
            end
            S_WRHOME: begin
                o_cmd.wr_home = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: sv/lpch_dp.sv
// ----------------------------------------------------------------------------
// lpch_dp
// slot memory, home slot divider, probe pointers, counters and result register
// ----------------------------------------------------------------------------
module lpch_dp
    import lpch_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_item           i_item,
    input  logic            i_cfg_wr,
    input  logic [CapW-1:0] i_cfg_data,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    output t_result         o_result,
    output logic            o_done
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CapW-1:0] CapMax =
        (TABLE_DEPTH > EntryMax) ? CapW'(EntryMax) : CapW'(TABLE_DEPTH);
    localparam logic [AW-1:0] ClrLast = AW'(TABLE_DEPTH - 1);

    t_slot mem [TABLE_DEPTH];

    logic [CapW-1:0] r_cap;
    logic [CapW-1:0] w_cap;
    logic [AW-1:0]   r_clr;
    logic [AW-1:0]   r_at, r_home, n_at;
    logic [CapW-1:0] r_n;
    logic [31:0]     r_dvd;
    logic [CapW-1:0] r_rem, n_rem;
    logic [CapW:0]   w_trial;
    logic [4:0]      r_dcnt;
    logic            r_mode;
    t_slot           r_sav, r_rdata;
    t_status         r_status;
    logic            r_found, r_miss;
    logic [31:0]     r_acc, r_mis;
    logic [8:0]      r_ent;
    t_result         r_res;
    logic            r_done;
    logic [15:0]     w_h;

    logic [AW-1:0]   w_addr;
    t_slot           w_wdata;
    logic            w_we, w_re;

    // effective capacity, zero taken as one, clipped to CapMax
    always_comb begin
        w_cap = (r_cap == '0) ? CapW'(1) : r_cap;
        if (w_cap > CapMax) begin
            w_cap = CapMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CapW'(256);
        end else if (i_cfg_wr) begin
            r_cap <= i_cfg_data;
        end
    end

    // restoring remainder, one dividend bit a cycle
    assign w_trial = {r_rem, r_dvd[31]};
    assign n_rem   = (w_trial >= {1'b0, w_cap}) ? CapW'(w_trial - {1'b0, w_cap})
                                                 : CapW'(w_trial);
    assign n_at    = ((32'(r_at) + 32'd1) >= 32'(w_cap)) ? '0 : r_at + AW'(1);
    assign w_h     = i_item.key_x ^ i_item.key_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd  <= {{16{w_h[15]}}, w_h};
            r_rem  <= '0;
            r_mode <= i_item.mode;
            r_sav  <= {1'b1, i_item.key_x, i_item.key_y, i_item.entry_flags,
                       i_item.entry_id};
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem;
            if (o_stat.div_last) begin
                r_home <= AW'(n_rem);
                r_at   <= AW'(n_rem);
                r_n    <= '0;
            end
        end
        if (i_cmd.step) begin
            r_at <= n_at;
            r_n  <= r_n + CapW'(1);
        end
        if (i_cmd.save) begin
            r_sav <= r_rdata;
        end
        if (i_cmd.set_res) begin
            r_status <= i_cmd.res_status;
            r_found  <= i_cmd.res_found;
            r_miss   <= i_cmd.res_miss;
        end
    end

    // single port slot memory
    always_comb begin
        w_addr  = r_at;
        w_wdata = r_rdata;
        if (i_cmd.clr_wr) begin
            w_addr  = r_clr;
            w_wdata = '0;
        end else if (i_cmd.rd_home || i_cmd.wr_home) begin
            w_addr  = r_home;
            w_wdata = r_sav;
        end
    end

    assign w_we = i_cmd.clr_wr | i_cmd.wr_at | i_cmd.wr_home;
    assign w_re = i_cmd.rd_at | i_cmd.rd_home;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= mem[w_addr];
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_clr == ClrLast);
        o_stat.div_last   = (r_dcnt == 5'(DivSteps - 1));
        o_stat.is_lookup  = (r_mode == MODE_LOOKUP);
        o_stat.rd_valid   = r_rdata.valid;
        o_stat.rd_match   = (r_rdata.x == r_sav.x) && (r_rdata.y == r_sav.y);
        o_stat.at_home    = (r_at == r_home);
        o_stat.sweep_last = (r_n == w_cap - CapW'(1));
    end

    // running counters and the result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_mis  <= '0;
            r_ent  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.fin;
            if (i_cmd.fin) begin
                r_acc <= r_acc + 32'd1;
                r_mis <= r_mis + 32'(r_miss);
                if (r_mode == MODE_INSERT && r_status == ST_OK
                        && r_ent != 9'(EntryMax)) begin
                    r_ent <= r_ent + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_res.found        <= r_found;
            r_res.out_flags    <= r_found ? r_sav.flags : '0;
            r_res.out_id       <= r_found ? r_sav.id : '0;
            r_res.status       <= r_status;
            r_res.access_count <= r_acc + 32'd1;
            r_res.miss_count   <= r_mis + 32'(r_miss);
            r_res.entry_count  <= (r_mode == MODE_INSERT && r_status == ST_OK
                                   && r_ent != 9'(EntryMax)) ? r_ent + 9'd1 : r_ent;
        end
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

FILE: sv/linear_probe_coord_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_coord_hash_table_core
// open-addressed hash table on 2-d coordinates with linear probing
// ----------------------------------------------------------------------------
// steps: load, bit-serial home slot division, a read and a check per probed slot,
//   a move or swap through the home slot where needed, then finish, with the result
//   strobe on the cycle after that; one operation at a time, set by the bit-serial
//   home slot divider and the single port slot memory
// after reset a clearing pass frees every slot, with busy high;
//   configuration writes are taken only while busy is low
// the receiver cannot stall: o_done is high for exactly one cycle per result
module linear_probe_coord_hash_table_core
    import lpch_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_item           i_item,
    output t_result         o_result,
    output logic            o_done,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CapW-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // no capacity change while an operation is in flight
    assign o_cfg_ready = ~busy;

    lpch_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    lpch_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_wr   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_result   (o_result),
        .o_done     (o_done)
    );

endmodule

FILE: verif/linear_probe_coord_hash_table_core_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_coord_hash_table_core_tb
// checks the coordinate hash table against a behavioural copy of its slot
// store: directed corner keys, capacity extremes, then random insert and
// lookup traffic over a range of capacities with varying sender gaps
// ----------------------------------------------------------------------------
module linear_probe_coord_hash_table_core_tb
    import lpch_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = TableDepthDefault;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_item           i_item = '0;
    t_result         o_result;
    logic            o_done;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [CapW-1:0] i_cfg_data = '0;

    linear_probe_coord_hash_table_core #(.TABLE_DEPTH(Depth)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_result   (o_result),
        .o_done     (o_done),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the table, every slot free after reset
    t_slot       slots_mdl [Depth] = '{default: '0};
    logic [31:0] accesses_mdl = '0;
    logic [31:0] misses_mdl = '0;
    logic [8:0]  entries_mdl = '0;
    logic [8:0]  capacity_mdl = 9'd256;

    t_result     pending_results [$];
    logic [15:0] inserted_x [$];
    logic [15:0] inserted_y [$];
    int          fail_count = 0;
    int          idle_pct = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("simulation failed");
        $finish;
    end

    function automatic t_result hash_table_op(t_item it);
        int unsigned cap;
        int unsigned home;
        int unsigned at;
        logic [31:0] h;
        logic [15:0] kx;
        logic [15:0] ky;
        bit          done;
        t_slot       tmp;
        t_result     r;
        r = '0;
        done = 1'b0;
        kx = it.key_x;
        ky = it.key_y;
        cap = (capacity_mdl == 0) ? 1 : (capacity_mdl > Depth) ? Depth : capacity_mdl;
        h = {{16{kx[15] ^ ky[15]}}, kx ^ ky};
        home = h % cap;
        at = home;
        accesses_mdl++;
        if (it.mode == MODE_INSERT) begin
            for (int n = 0; n < cap; n++) begin
                if (!slots_mdl[at].valid) begin
                    done = 1'b1;
                    break;
                end
                at = (at + 1 >= cap) ? 0 : at + 1;
            end
            if (!done) begin
                r.status = ST_FULL;
            end else begin
                r.status = ST_OK;
                if (at != home) begin
                    misses_mdl++;
                    slots_mdl[at] = slots_mdl[home];
                end
                slots_mdl[home] = '{1'b1, kx, ky, it.entry_flags, it.entry_id};
                if (entries_mdl < EntryMax) entries_mdl++;
                inserted_x.push_back(kx);
                inserted_y.push_back(ky);
            end
        end else begin
            r.status = ST_NOT_FOUND;
            for (int n = 0; n < cap; n++) begin
                if (!slots_mdl[at].valid) begin
                    if (at != home) misses_mdl++;
                    break;
                end
                if (slots_mdl[at].x == kx && slots_mdl[at].y == ky) begin
                    if (at != home) begin
                        // bring the hit to its home slot
                        tmp = slots_mdl[home];
                        misses_mdl++;
                        slots_mdl[home] = slots_mdl[at];
                        slots_mdl[at] = tmp;
                    end
                    r.found = 1'b1;
                    r.out_flags = slots_mdl[home].flags;
                    r.out_id = slots_mdl[home].id;
                    r.status = ST_OK;
                    break;
                end
                at = (at + 1 >= cap) ? 0 : at + 1;
            end
        end
        r.access_count = accesses_mdl;
        r.miss_count = misses_mdl;
        r.entry_count = entries_mdl;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", want.found, o_result.found);
                check_field("out_flags", want.out_flags, o_result.out_flags);
                check_field("out_id", want.out_id, o_result.out_id);
                check_field("status", want.status, o_result.status);
                check_field("access_count", want.access_count, o_result.access_count);
                check_field("miss_count", want.miss_count, o_result.miss_count);
                check_field("entry_count", want.entry_count, o_result.entry_count);
            end
        end
    end

    // called at a rising edge; returns at the edge that takes the transaction, or after a random idle gap
    task automatic send_op(t_item it);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(hash_table_op(it));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_key(logic mode, logic [15:0] x, logic [15:0] y,
                            logic [7:0] fl, logic [15:0] id);
        t_item it;
        it.mode = mode;
        it.key_x = x;
        it.key_y = y;
        it.entry_flags = fl;
        it.entry_id = id;
        send_op(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CapW-1:0] v);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        capacity_mdl = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_corner_keys();
        send_key(MODE_INSERT, 16'h8000, 16'h0000, 8'hff, 16'hffff);
        send_key(MODE_INSERT, 16'h7fff, 16'h7fff, 8'h01, 16'h0001);
        // same home as the previous key, which is pushed along
        send_key(MODE_INSERT, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        send_key(MODE_LOOKUP, 16'h7fff, 16'h7fff, 8'hff, 16'hffff);
        send_key(MODE_LOOKUP, 16'h0001, 16'h0001, 8'h00, 16'h0000);
        send_key(MODE_LOOKUP, 16'h8000, 16'h0000, 8'h00, 16'h0000);
        send_key(MODE_INSERT, 16'hffff, 16'h0000, 8'haa, 16'h5555);
        // home 255 occupied, wraps to the bottom of the table
        send_key(MODE_INSERT, 16'h0005, 16'hfffa, 8'h55, 16'haaaa);
        send_key(MODE_LOOKUP, 16'hffff, 16'h0000, 8'h00, 16'h0000);
        send_key(MODE_LOOKUP, 16'h0005, 16'hfffa, 8'h00, 16'h0000);
        send_key(MODE_INSERT, 16'h0000, 16'h0000, 8'h3c, 16'h1234);
        send_key(MODE_LOOKUP, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        send_key(MODE_LOOKUP, 16'h1234, 16'h5678, 8'h00, 16'h0000);
    endtask

    task automatic test_capacity_extremes();
        // zero is taken as one slot
        write_capacity(9'd0);
        send_key(MODE_INSERT, 16'h0003, 16'h0009, 8'h11, 16'h2222);
        send_key(MODE_LOOKUP, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        send_key(MODE_LOOKUP, 16'h0009, 16'h0009, 8'h00, 16'h0000);
        write_capacity(9'd1);
        send_key(MODE_INSERT, 16'h7fff, 16'h8000, 8'h80, 16'h8000);
        send_key(MODE_LOOKUP, 16'h0000, 16'h0000, 8'h00, 16'h0000);
        write_capacity(9'd2);
        send_key(MODE_INSERT, 16'h0001, 16'h0000, 8'h7f, 16'h7fff);
        send_key(MODE_INSERT, 16'h0002, 16'h0000, 8'h01, 16'h0002);
        send_key(MODE_LOOKUP, 16'h0001, 16'h0000, 8'h00, 16'h0000);
        // above the table depth, clipped
        write_capacity(9'd511);
        send_key(MODE_LOOKUP, 16'h0005, 16'hfffa, 8'h00, 16'h0000);
    endtask

    task automatic random_phase(logic [CapW-1:0] cap, int count, bit with_pauses);
        t_item it;
        int    k;
        write_capacity(cap);
        for (int i = 0; i < count; i++) begin
            it = t_item'(57'({$urandom, $urandom}));
            it.mode = ($urandom_range(99) < 50) ? MODE_INSERT : MODE_LOOKUP;
            if (inserted_x.size() != 0 && $urandom_range(99) < 60) begin
                k = $urandom_range(inserted_x.size() - 1);
                it.key_x = inserted_x[k];
                it.key_y = inserted_y[k];
            end else if ($urandom_range(99) < 40) begin
                // small hashes to crowd the low slots
                it.key_y = it.key_x ^ 16'($urandom_range(cap + 3));
            end
            send_op(it);
            if (with_pauses && $urandom_range(99) < 3) drain();
        end
    endtask

    task automatic test_random_traffic();
        idle_pct = 36;
        random_phase(9'd3, 200, 1'b1);
        random_phase(9'd8, 200, 1'b0);
        random_phase(9'd17, 200, 1'b0);
        idle_pct = 70;
        random_phase(9'd40, 200, 1'b0);
        random_phase(9'd100, 200, 1'b1);
        idle_pct = 0;
        random_phase(9'd300, 250, 1'b0);
        random_phase(9'd256, 270, 1'b0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 36;
        test_corner_keys();
        test_capacity_extremes();
        test_random_traffic();
        drain();
        repeat (600) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
